// ===== hdl/vgmpsg_pkg.sv =====
// shared types and constants for the command stream tracker
package vgmpsg_pkg;

	typedef enum logic [2:0] {
		EV_LATCH_PERIOD = 3'd0,
		EV_LATCH_VOLUME = 3'd1,
		EV_DATA_PERIOD  = 3'd2,
		EV_DATA_VOLUME  = 3'd3,
		EV_END          = 3'd4,
		EV_UNKNOWN      = 3'd5
	} event_t;

	localparam int unsigned NUM_CHAN = 4;

	localparam logic [7:0] OP_PSG_WRITE = 8'h50;
	localparam logic [7:0] OP_WAIT_N    = 8'h61;
	localparam logic [7:0] OP_WAIT_NTSC = 8'h62;
	localparam logic [7:0] OP_WAIT_PAL  = 8'h63;
	localparam logic [7:0] OP_END       = 8'h66;
	localparam logic [7:0] OP_DATA_BLK  = 8'h67;
	localparam logic [7:0] OP_PCM_WRITE = 8'h68;
	localparam logic [7:0] OP_SEEK      = 8'hE0;
	localparam logic [7:0] OP_STEREO    = 8'h4F;

	localparam logic [31:0] WAIT_NTSC_TICKS = 32'd735;
	localparam logic [31:0] WAIT_PAL_TICKS  = 32'd882;

	localparam logic [31:0] BLK_HDR_LEN = 32'd6;
	localparam logic [31:0] PCM_LEN     = 32'd11;

	// write to the sound generator, one per accepted data byte
	typedef struct packed {
		logic       en;
		logic [7:0] data;
	} psg_wr_t;

	// stream level event from the parser
	typedef struct packed {
		logic       en;
		event_t     code;
		logic [7:0] opcode;
	} cmd_evt_t;

	// register view after the current item
	typedef struct packed {
		logic [1:0]                    channel;
		event_t                        code;
		logic [NUM_CHAN-1:0][9:0]      period;
		logic [NUM_CHAN-1:0][7:0]      volume;
	} psg_view_t;

endpackage

// ===== hdl/vgmpsg_byte_if.sv =====
// input channel: one stream byte per item
interface vgmpsg_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] stream_byte;

	modport source (output valid, output stream_byte, input ready);
	modport sink (input valid, input stream_byte, output ready);
endinterface

// ===== hdl/vgmpsg_event_if.sv =====
// output channel: one event with the register snapshot per item
interface vgmpsg_event_if;
	logic        valid;
	logic        ready;
	logic [2:0]  event_res;
	logic [1:0]  channel;
	logic [7:0]  written_byte;
	logic [31:0] tick_now;
	logic [9:0]  period_zero;
	logic [9:0]  period_one;
	logic [9:0]  period_two;
	logic [9:0]  period_noise;
	logic [7:0]  volume_zero;
	logic [7:0]  volume_one;
	logic [7:0]  volume_two;
	logic [7:0]  volume_noise;

	modport source (
		output valid, output event_res, output channel, output written_byte,
		output tick_now, output period_zero, output period_one, output period_two,
		output period_noise, output volume_zero, output volume_one, output volume_two,
		output volume_noise, input ready
	);
	modport sink (
		input valid, input event_res, input channel, input written_byte,
		input tick_now, input period_zero, input period_one, input period_two,
		input period_noise, input volume_zero, input volume_one, input volume_two,
		input volume_noise, output ready
	);
endinterface

// ===== hdl/vgmpsg_parser.sv =====
// command parser: opcode sizing, operand skipping and tick count
module vgmpsg_parser (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  take,
	input  logic [7:0]            stream_byte,
	output vgmpsg_pkg::psg_wr_t   psg_wr,
	output vgmpsg_pkg::cmd_evt_t  cmd_evt,
	output logic [31:0]           tick_now
);
	import vgmpsg_pkg::*;

	typedef enum logic [2:0] {
		PH_OPCODE,
		PH_WRITE,
		PH_WAIT,
		PH_SKIP,
		PH_HEADER,
		PH_BODY,
		PH_HALT
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [31:0] skip_q, skip_d;
	logic [31:0] gather_q, gather_d;
	logic [31:0] tick_q, tick_d;
	logic [31:0] addend;
	logic [31:0] gather_sh;
	logic [31:0] skip_dec;

	assign gather_sh = {stream_byte, gather_q[31:8]};
	assign skip_dec  = skip_q - 32'd1;
	assign tick_d    = tick_q + addend;
	assign tick_now  = tick_q;

	always_comb begin
		phase_d  = phase_q;
		skip_d   = skip_q;
		gather_d = gather_q;
		addend   = '0;
		psg_wr   = '{en: 1'b0, data: stream_byte};
		cmd_evt  = '{en: 1'b0, code: EV_END, opcode: stream_byte};
		case (phase_q)
			PH_OPCODE: begin
				gather_d = '0;
				phase_d  = PH_SKIP;
				case (stream_byte) inside
					OP_END: begin
						cmd_evt.en = 1'b1;
						phase_d    = PH_HALT;
					end
					OP_PSG_WRITE: phase_d = PH_WRITE;
					OP_WAIT_N: begin
						skip_d  = 32'd2;
						phase_d = PH_WAIT;
					end
					OP_WAIT_NTSC: begin
						addend  = WAIT_NTSC_TICKS;
						phase_d = PH_OPCODE;
					end
					OP_WAIT_PAL: begin
						addend  = WAIT_PAL_TICKS;
						phase_d = PH_OPCODE;
					end
					[8'h70:8'h7F]: begin
						addend  = {28'd0, stream_byte[3:0]} + 32'd1;
						phase_d = PH_OPCODE;
					end
					[8'h80:8'h8F]: begin
						addend  = {28'd0, stream_byte[3:0]};
						phase_d = PH_OPCODE;
					end
					OP_DATA_BLK: begin
						skip_d  = BLK_HDR_LEN;
						phase_d = PH_HEADER;
					end
					OP_PCM_WRITE: skip_d = PCM_LEN;
					OP_SEEK:      skip_d = 32'd4;
					[8'h30:8'h3F]: skip_d = 32'd1;
					[8'h40:8'h4E]: skip_d = 32'd2;
					OP_STEREO:    skip_d = 32'd1;
					[8'h51:8'h5F]: skip_d = 32'd2;
					[8'hA0:8'hBF]: skip_d = 32'd2;
					[8'hC0:8'hDF]: skip_d = 32'd3;
					[8'hE1:8'hFF]: skip_d = 32'd4;
					default: begin
						cmd_evt.en   = 1'b1;
						cmd_evt.code = EV_UNKNOWN;
						phase_d      = PH_HALT;
					end
				endcase
			end
			PH_WRITE: begin
				psg_wr.en = 1'b1;
				phase_d   = PH_OPCODE;
			end
			PH_WAIT: begin
				gather_d = gather_sh;
				skip_d   = skip_dec;
				if (skip_dec == '0) begin
					addend  = {16'd0, gather_sh[31:16]};
					phase_d = PH_OPCODE;
				end
			end
			PH_HEADER: begin
				if (skip_q <= 32'd4) begin
					gather_d = gather_sh;
				end
				skip_d = skip_dec;
				if (skip_dec == '0) begin
					skip_d  = gather_d;
					phase_d = (gather_d == '0) ? PH_OPCODE : PH_BODY;
				end
			end
			PH_SKIP, PH_BODY: begin
				if (skip_q != '0) begin
					skip_d = skip_dec;
				end
				if (skip_q <= 32'd1) begin
					phase_d = PH_OPCODE;
				end
			end
			PH_HALT: phase_d = PH_HALT;
			default: phase_d = PH_OPCODE;
		endcase
		if (!take) begin
			psg_wr.en  = 1'b0;
			cmd_evt.en = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_OPCODE;
			skip_q   <= '0;
			gather_q <= '0;
			tick_q   <= '0;
		end else if (take) begin
			phase_q  <= phase_d;
			skip_q   <= skip_d;
			gather_q <= gather_d;
			tick_q   <= tick_d;
		end
	end

endmodule

// ===== hdl/vgmpsg_psg_regs.sv =====
// sound generator latch, period and attenuation registers
module vgmpsg_psg_regs (
	input  logic                  clk,
	input  logic                  arst_n,
	input  vgmpsg_pkg::psg_wr_t   psg_wr,
	output vgmpsg_pkg::psg_view_t view
);
	import vgmpsg_pkg::*;

	logic [2:0]                latch_q, latch_d;
	logic [NUM_CHAN-1:0][9:0]  period_q, period_d;
	logic [NUM_CHAN-1:0][7:0]  volume_q, volume_d;
	logic [1:0]                ch;
	event_t                    code;

	always_comb begin
		latch_d  = latch_q;
		period_d = period_q;
		volume_d = volume_q;
		code     = EV_DATA_VOLUME;
		if (psg_wr.data[7]) begin
			latch_d = psg_wr.data[6:4];
		end
		ch = latch_d[2:1];
		if (psg_wr.data[7]) begin
			if (!latch_d[0]) begin
				period_d[ch] = {period_q[ch][9:4], psg_wr.data[3:0]};
				code         = EV_LATCH_PERIOD;
			end else begin
				volume_d[ch] = {4'd0, psg_wr.data[3:0]};
				code         = EV_LATCH_VOLUME;
			end
		end else if (!latch_d[0]) begin
			period_d[ch] = {psg_wr.data[5:0], period_q[ch][3:0]};
			code         = EV_DATA_PERIOD;
		end
		if (!psg_wr.en) begin
			latch_d  = latch_q;
			period_d = period_q;
			volume_d = volume_q;
		end
		view = '{channel: latch_d[2:1], code: code, period: period_d, volume: volume_d};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latch_q  <= '0;
			period_q <= '0;
			volume_q <= '1;
		end else begin
			latch_q  <= latch_d;
			period_q <= period_d;
			volume_q <= volume_d;
		end
	end

endmodule

// ===== hdl/vgm_psg_command_tracker.sv =====
// top level: command stream tracker with registered event output
// an event is registered when its byte is accepted and shows on evt in the next cycle
// throughput: one byte per cycle; cmd stalls only while a held event is not taken
// while an event is held, cmd.ready follows evt.ready combinationally
// reset: parser expects an opcode, ticks and periods zero, attenuations 255, no event held
module vgm_psg_command_tracker (
	input  logic           clk,
	input  logic           arst_n,
	vgmpsg_byte_if.sink    cmd,
	vgmpsg_event_if.source evt
);
	import vgmpsg_pkg::*;

	logic                      take;
	psg_wr_t                   psg_wr;
	cmd_evt_t                  cmd_evt;
	psg_view_t                 view;
	logic [31:0]               tick_now;
	logic                      out_valid_q;
	logic [2:0]                event_q;
	logic [1:0]                channel_q;
	logic [7:0]                byte_q;
	logic [31:0]               tick_q;
	logic [NUM_CHAN-1:0][9:0]  period_q;
	logic [NUM_CHAN-1:0][7:0]  volume_q;

	assign cmd.ready = !out_valid_q || evt.ready;
	assign take      = cmd.valid && cmd.ready;

	vgmpsg_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.stream_byte (cmd.stream_byte),
		.psg_wr      (psg_wr),
		.cmd_evt     (cmd_evt),
		.tick_now    (tick_now)
	);

	vgmpsg_psg_regs u_psg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psg_wr (psg_wr),
		.view   (view)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (psg_wr.en || cmd_evt.en) begin
			out_valid_q <= 1'b1;
		end else if (evt.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (psg_wr.en || cmd_evt.en) begin
			event_q   <= cmd_evt.en ? cmd_evt.code : view.code;
			byte_q    <= cmd_evt.en ? cmd_evt.opcode : psg_wr.data;
			channel_q <= view.channel;
			tick_q    <= tick_now;
			period_q  <= view.period;
			volume_q  <= view.volume;
		end
	end

	assign evt.valid        = out_valid_q;
	assign evt.event_res    = event_q;
	assign evt.channel      = channel_q;
	assign evt.written_byte = byte_q;
	assign evt.tick_now     = tick_q;
	assign evt.period_zero  = period_q[0];
	assign evt.period_one   = period_q[1];
	assign evt.period_two   = period_q[2];
	assign evt.period_noise = period_q[3];
	assign evt.volume_zero  = volume_q[0];
	assign evt.volume_one   = volume_q[1];
	assign evt.volume_two   = volume_q[2];
	assign evt.volume_noise = volume_q[3];

endmodule
